// ===== rtl/breakpoint_comparator_slots_unit_defines.svh =====
// Assertion macros for the breakpoint comparator slot unit.
// Used by the top level; expects clk and rst_n in scope.
`ifndef BREAKPOINT_COMPARATOR_SLOTS_UNIT_DEFINES_SVH
`define BREAKPOINT_COMPARATOR_SLOTS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bpc_pkg.sv =====
// Shared types and constants for the breakpoint comparator slot unit.
// No dependencies.
package bpc_pkg;

  localparam int SLOT_COUNT_DEF = 6;

  localparam logic [1:0] HALF_LOW  = 2'b01;
  localparam logic [1:0] HALF_HIGH = 2'b10;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_SLOT = 2'd1;
  localparam logic [1:0] STATUS_ODD     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        action;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        write_valid;
    logic [2:0]  slot_index;
    logic [31:0] comparator_value;
  } out_item_t;

  typedef struct packed {
    logic word_match;
    logic slot_free;
    logic hit;
  } cmp_res_t;

endpackage

// ===== rtl/bpc_slot_cmp.sv =====
// Shared slot comparator: checks one stored slot against the request.
// Depends on bpc_pkg.
module bpc_slot_cmp (
  input  logic [29:0]      slot_word,
  input  logic [1:0]       slot_bits,
  input  logic [29:0]      req_word,
  input  logic             req_set,
  output bpc_pkg::cmp_res_t res
);

  always_comb begin
    res.word_match = (slot_word == req_word);
    res.slot_free  = (slot_bits == 2'b00);
    // a free slot only counts when setting
    res.hit        = res.word_match | (req_set & res.slot_free);
  end

endmodule

// ===== rtl/breakpoint_comparator_slots_unit.sv =====
// Breakpoint comparator slot unit: top level with scan sequencer and slot table.
// Depends on bpc_pkg, bpc_slot_cmp and breakpoint_comparator_slots_unit_defines.svh.
//
// Usage: a request item (action, address) enters on in_valid/in_stall; one
// result item (status, write_valid, slot_index, comparator_value) leaves on
// out_valid/out_stall for every request. An item is taken when valid is high
// and stall is low.
// Timing: the sequencer walks the slot table one slot per cycle through a
// single shared comparator, stopping at the first hit. A request passes
// through the accept state, a scan of up to SLOT_COUNT slots and the finish
// state; an odd address skips the scan.
// in_stall stays high from acceptance until the finish cycle completes.
// The result lands in an output register; the next request is accepted while
// it waits. If out_stall holds that register, the finish cycle waits too and
// the slot table is updated only when the result is loaded.
// Reset: all slots are cleared (word address zero, both halfword bits clear),
// no result is pending and the unit is ready for a request.
`include "breakpoint_comparator_slots_unit_defines.svh"

module breakpoint_comparator_slots_unit #(
  parameter int SLOT_COUNT = bpc_pkg::SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bpc_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output bpc_pkg::out_item_t  out_item
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

  bpc_pkg::state_t    state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  bpc_pkg::in_item_t  req_r;
  logic               found_r, found_nxt;
  logic               odd_r;
  bpc_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r;

  logic [29:0]        slot_word_r [SLOT_COUNT];
  logic [1:0]         slot_bits_r [SLOT_COUNT];

  bpc_pkg::cmp_res_t  cmp;
  logic               accept;
  logic               load_out;
  logic               slot_we;
  logic [29:0]        req_word;
  logic [1:0]         half;
  logic [1:0]         cur_bits;
  logic [1:0]         new_bits;
  logic [31:0]        idx_ext;

  assign req_word = req_r.address[31:2];
  assign cur_bits = slot_bits_r[idx_r];

  bpc_slot_cmp u_cmp (
    .slot_word (slot_word_r[idx_r]),
    .slot_bits (cur_bits),
    .req_word  (req_word),
    .req_set   (req_r.action),
    .res       (cmp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_item.address[0] ? bpc_pkg::ST_DONE : bpc_pkg::ST_SCAN;
        end
      end
      bpc_pkg::ST_SCAN: begin
        if (cmp.hit || idx_r == IDX_LAST) begin
          state_nxt = bpc_pkg::ST_DONE;
        end
      end
      bpc_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = bpc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bpc_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    in_stall  = 1'b1;
    accept    = 1'b0;
    load_out  = 1'b0;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    unique case (state_r)
      bpc_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        accept    = in_valid;
        idx_nxt   = '0;
        found_nxt = 1'b0;
      end
      bpc_pkg::ST_SCAN: begin
        if (cmp.hit) begin
          found_nxt = 1'b1;
        end else if (idx_r != IDX_LAST) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      bpc_pkg::ST_DONE: begin
        load_out = !out_valid_r || !out_stall;
      end
      default: ;
    endcase
  end

  // Result word for the finish cycle
  always_comb begin
    half    = req_r.address[1] ? bpc_pkg::HALF_HIGH : bpc_pkg::HALF_LOW;
    idx_ext = 32'(idx_r);
    if (req_r.action) begin
      new_bits = cur_bits | half;
    end else begin
      new_bits = cur_bits & ~half;
    end
    out_nxt = '0;
    if (odd_r) begin
      out_nxt.status = bpc_pkg::STATUS_ODD;
    end else if (!found_r) begin
      out_nxt.status = req_r.action ? bpc_pkg::STATUS_NO_SLOT : bpc_pkg::STATUS_OK;
    end else begin
      out_nxt.status      = bpc_pkg::STATUS_OK;
      out_nxt.write_valid = 1'b1;
      out_nxt.slot_index  = idx_ext[2:0];
      if (new_bits != 2'b00) begin
        out_nxt.comparator_value = {new_bits, 30'd0} | {req_word, 2'b01};
      end
    end
    slot_we = load_out && found_r && !odd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpc_pkg::ST_IDLE;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      found_r <= found_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
      odd_r <= in_item.address[0];
    end
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_word_r[i] <= '0;
        slot_bits_r[i] <= '0;
      end
    end else if (slot_we) begin
      slot_word_r[idx_r] <= req_word;
      slot_bits_r[idx_r] <= new_bits;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `BPC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
                   "request accepted but unit not busy next cycle")
  `BPC_ASSERT_NOW(a_write_means_ok, out_valid && out_item.write_valid,
                  out_item.status == bpc_pkg::STATUS_OK,
                  "write issued with error status")
  `BPC_ASSERT_NOW(a_enable_bit, out_valid && out_item.comparator_value != 32'd0,
                  out_item.comparator_value[0] && out_item.write_valid,
                  "nonzero comparator word without enable or write")
  `BPC_ASSERT_NOW(a_no_write_no_data, out_valid && !out_item.write_valid,
                  out_item.comparator_value == 32'd0 && out_item.slot_index == 3'd0,
                  "result without write carries slot data")

endmodule
